@@ design/nearest_palette_color_map_core_macros.svh @@
// Assertion macros for the nearest palette color map core.
`ifndef NEAREST_PALETTE_COLOR_MAP_CORE_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MAP_CORE_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define NPCM_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset disables the check.
`define NPCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/npcm_pkg.sv @@
// Shared types, constants and distance helpers for the palette color map.
`timescale 1ns / 1ps

package npcm_pkg;

  // Palette geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int CMP_W         = (CNT_W > 9) ? CNT_W : 9;

  // Distance arithmetic
  localparam int CH_W          = 8;
  localparam int CH_R_LSB      = 16;
  localparam int CH_G_LSB      = 8;
  localparam int CH_B_LSB      = 0;
  localparam int SQ_W          = 18;
  localparam int ROOT_W        = 19;
  localparam int DIST_W        = 9;
  localparam logic [DIST_W-1:0] BEST_INIT = DIST_W'(256);

  // Integer square root: 9 digit steps, 3 per pipeline stage
  localparam int ISQ_ITER      = 9;
  localparam int ISQ_PER_STAGE = 3;
  localparam int ISQ_STAGES    = ISQ_ITER / ISQ_PER_STAGE;

  // Registers between a pixel word entering a cell and its distance being ready
  localparam int SKEW          = ISQ_STAGES + 1;

  // Positions a pixel can occupy between input and result register
  localparam int CHAIN_LEN     = 1 + SKEW + PALETTE_DEPTH;
  localparam int FL_W          = $clog2(CHAIN_LEN + 1);

  // Command codes
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_MAP   = 1'b1
  } cmd_t;

  // Configuration register indexes
  localparam logic REG_PALETTE_SIZE = 1'b0;
  localparam logic REG_TRANS_INDEX  = 1'b1;

  // Search state handed from cell to cell
  typedef struct packed {
    logic              fend;
    logic [DIST_W-1:0] best;
    logic [31:0]       matched;
    logic              hit;
    logic [31:0]       tword;
  } px_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic             wr_valid;
    logic [CMP_W-1:0] wr_index;
    logic [31:0]      wr_word;
    logic [CMP_W-1:0] size;
    logic             trans_en;
    logic [CMP_W-1:0] trans_idx;
  } cell_ctl_t;

  // Partial square root state
  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } isq_t;

  function automatic logic [15:0] chan_sq(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  function automatic logic [SQ_W-1:0] sq_sum(logic [31:0] a, logic [31:0] b);
    return SQ_W'(chan_sq(a[CH_R_LSB +: CH_W], b[CH_R_LSB +: CH_W]))
         + SQ_W'(chan_sq(a[CH_G_LSB +: CH_W], b[CH_G_LSB +: CH_W]))
         + SQ_W'(chan_sq(a[CH_B_LSB +: CH_W], b[CH_B_LSB +: CH_W]));
  endfunction

  // One digit step of the restoring square root
  function automatic isq_t isq_iter(isq_t s, int unsigned i);
    isq_t              r;
    logic [ROOT_W-1:0] b;
    logic [ROOT_W-1:0] trial;
    b     = ROOT_W'(1) << (2 * (ISQ_ITER - 1 - i));
    trial = s.root + b;
    r     = s;
    if (ROOT_W'(s.rem) >= trial) begin
      r.rem  = s.rem - SQ_W'(trial);
      r.root = (s.root >> 1) + b;
    end else begin
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // The steps that belong to one pipeline stage
  function automatic isq_t isq_run(isq_t s, int unsigned stage);
    isq_t r;
    r = s;
    for (int unsigned j = 0; j < ISQ_PER_STAGE; j++) begin
      r = isq_iter(r, stage * ISQ_PER_STAGE + j);
    end
    return r;
  endfunction

endpackage

@@ design/npcm_cell.sv @@
// One palette cell: holds an entry, computes its distance, updates the best match.
`timescale 1ns / 1ps

module npcm_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic [npcm_pkg::CMP_W-1:0]   cell_idx,
  input  npcm_pkg::cell_ctl_t          ctl,
  input  logic [31:0]                  word_in,
  output logic [31:0]                  word_out,
  input  logic                         valid_in,
  input  npcm_pkg::px_t                px_in,
  output logic                         valid_out,
  output npcm_pkg::px_t                px_out
);
  import npcm_pkg::*;

  logic [31:0]       entry;
  logic [SQ_W-1:0]   sq;
  isq_t              st [ISQ_STAGES];
  logic [DIST_W-1:0] entry_dist;
  logic              take;
  logic              grab_trans;
  px_t               px_next;

  // Palette entry storage
  always_ff @(posedge clk) begin
    if (ctl.wr_valid && (ctl.wr_index == cell_idx)) begin
      entry <= ctl.wr_word;
    end
  end

  // Pixel word moves on; distance pipeline runs SKEW stages behind it
  always_ff @(posedge clk) begin
    if (adv) begin
      word_out <= word_in;
      sq       <= sq_sum(word_in, entry);
      st[0]    <= isq_run(isq_t'{rem: sq, root: '0}, 0);
      for (int unsigned s = 1; s < ISQ_STAGES; s++) begin
        st[s] <= isq_run(st[s-1], s);
      end
    end
  end

  assign entry_dist = st[ISQ_STAGES-1].root[DIST_W-1:0];

  // Strictly smaller distance wins; cells past the palette size stay out
  assign take       = (cell_idx < ctl.size) && (entry_dist < px_in.best);
  assign grab_trans = ctl.trans_en && (ctl.trans_idx == cell_idx);

  always_comb begin
    px_next = px_in;
    if (take) begin
      px_next.best    = entry_dist;
      px_next.matched = entry;
      px_next.hit     = 1'b1;
    end
    if (grab_trans) begin
      px_next.tword = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_out <= px_next;
    end
  end

endmodule

@@ design/nearest_palette_color_map_core.sv @@
// Nearest palette color map: top level with cell chain, config and result register.
//
// Usage:
//   Items arrive on the pix channel. command CMD_WRITE loads color_word into
//   palette entry entry_index and gives no result; command CMD_MAP searches the
//   first palette_size entries for the nearest RGB color and gives one result
//   on the res channel (mapped_color, palette_hit, frame_end_out).
//   Registers palette_size (index 0) and transparency_index (index 1) are
//   written over the cfg channel, which is always ready.
// Timing:
//   A pixel walks a chain of PALETTE_DEPTH cells, one cell per cycle while the
//   chain moves, with a SKEW-stage distance pipeline in each cell; one pixel
//   enters per cycle while the chain moves.
//   A palette write waits until no pixel is in flight between input and
//   result register.
// Reset: config returns to size 0 and transparency off, the chain and result
//   register empty; palette contents are undefined until written.
// Stall: the chain keeps moving while the result register waits, and freezes
//   only when a finished pixel reaches the end of the chain.
`timescale 1ns / 1ps
`include "nearest_palette_color_map_core_macros.svh"

module nearest_palette_color_map_core (
  input  logic        clk,
  input  logic        rst,
  // pixel / command channel
  input  logic        pix_valid,
  output logic        pix_ready,
  input  logic        command,
  input  logic [7:0]  entry_index,
  input  logic [31:0] color_word,
  input  logic        frame_end,
  // result channel
  output logic        res_valid,
  input  logic        res_ready,
  output logic [31:0] mapped_color,
  output logic        palette_hit,
  output logic        frame_end_out,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  import npcm_pkg::*;

  logic [8:0]        palette_size;
  logic signed [8:0] transparency_index;

  logic              adv;
  logic              pix_xfer;
  logic              map_xfer;
  logic              wr_xfer;
  logic              drain;
  logic [FL_W-1:0]   flight;
  cell_ctl_t         ctl;

  logic [31:0]       f_word;
  logic              f_valid;
  logic              f_fend;
  px_t               d_px    [SKEW];
  logic              d_valid [SKEW];

  logic [31:0]       wchain [PALETTE_DEPTH+1];
  px_t               pchain [PALETTE_DEPTH+1];
  logic              vchain [PALETTE_DEPTH+1];

  px_t               last_px;
  logic              last_valid;
  logic [31:0]       final_color;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size       <= '0;
      transparency_index <= -9'sd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PALETTE_SIZE: palette_size       <= cfg_data;
        REG_TRANS_INDEX:  transparency_index <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: chain freezes only if a done pixel would overrun the result
  assign last_px    = pchain[PALETTE_DEPTH];
  assign last_valid = vchain[PALETTE_DEPTH];
  assign adv        = !(last_valid && res_valid && !res_ready);
  assign drain      = adv && last_valid;

  assign pix_ready = adv && ((command == CMD_MAP) || (flight == '0));
  assign pix_xfer  = pix_valid && pix_ready;
  assign map_xfer  = pix_xfer && (command == CMD_MAP);
  assign wr_xfer   = pix_xfer && (command == CMD_WRITE);

  // Pixels in flight between input and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      flight <= '0;
    end else begin
      flight <= flight + FL_W'(map_xfer) - FL_W'(drain);
    end
  end

  // Broadcast control
  always_comb begin
    ctl.wr_valid  = wr_xfer;
    ctl.wr_index  = CMP_W'(entry_index);
    ctl.wr_word   = color_word;
    ctl.size      = CMP_W'(palette_size);
    ctl.trans_en  = !transparency_index[8]
                    && (CMP_W'(transparency_index[7:0]) < CMP_W'(PALETTE_DEPTH));
    ctl.trans_idx = CMP_W'(transparency_index[7:0]);
  end

  // Front register and a skew line of SKEW registers that holds search state back
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      for (int i = 0; i < SKEW; i++) begin
        d_valid[i] <= 1'b0;
      end
    end else if (adv) begin
      f_valid    <= map_xfer;
      d_valid[0] <= f_valid;
      for (int i = 1; i < SKEW; i++) begin
        d_valid[i] <= d_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_word <= color_word;
      f_fend <= frame_end;
      d_px[0] <= '{fend: f_fend, best: BEST_INIT, matched: f_word,
                   hit: 1'b0, tword: '0};
      for (int i = 1; i < SKEW; i++) begin
        d_px[i] <= d_px[i-1];
      end
    end
  end

  assign wchain[0] = f_word;
  assign pchain[0] = d_px[SKEW-1];
  assign vchain[0] = d_valid[SKEW-1];

  // Row of palette cells
  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    npcm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .cell_idx  (CMP_W'(k)),
      .ctl       (ctl),
      .word_in   (wchain[k]),
      .word_out  (wchain[k+1]),
      .valid_in  (vchain[k]),
      .px_in     (pchain[k]),
      .valid_out (vchain[k+1]),
      .px_out    (pchain[k+1])
    );
  end

  // Transparency: zero the result if it equals the transparency entry
  assign final_color = (ctl.trans_en && (last_px.matched == last_px.tword))
                       ? 32'd0 : last_px.matched;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (drain) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      mapped_color  <= final_color;
      palette_hit   <= last_px.hit;
      frame_end_out <= last_px.fend;
    end
  end

  // Checks
  `NPCM_ASSERT(a_write_on_empty, clk, rst, wr_xfer, flight == '0,
               "palette write with pixels in flight")
  `NPCM_ASSERT(a_flight_bound, clk, rst, 1'b1, flight <= FL_W'(CHAIN_LEN),
               "flight count overflow")
  `NPCM_ASSERT(a_stall_holds_input, clk, rst,
               res_valid && !res_ready && last_valid, !pix_ready,
               "input taken while chain frozen")
  `NPCM_ASSERT_NEXT(a_map_enters, clk, rst, map_xfer, f_valid,
                    "mapped pixel lost at chain entry")

endmodule
